### sv/pilb_pkg.sv
// Package for the position indicator LED blinker: payload types and constants.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none
package pilb_pkg;

  localparam int unsigned BLINK_PERIOD = 10;
  localparam int unsigned BLINK_HALF   = BLINK_PERIOD / 2;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned POS_W        = 3;
  localparam int unsigned ROW_W        = 8;
  localparam int unsigned DUTY_W       = 7;
  localparam int unsigned PCNT_W       = 4;
  localparam int unsigned SHIFT_BITS   = 16;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;

  localparam logic [DUTY_W-1:0] FLASH_DUTY = 7'd30;
  localparam logic [DUTY_W-1:0] MAX_DUTY   = 7'd100;
  localparam logic [ROW_W-1:0]  FULL_ROW   = 8'hff;
  localparam logic [PCNT_W-1:0] PCNT_RESET = 4'd8;

  localparam logic [0:0] REG_POSITION_COUNT = 1'b0;

  typedef struct packed {
    logic [POS_W-1:0]  current_position;
    logic [POS_W-1:0]  optimal_position;
    logic [DUTY_W-1:0] brightness_setting;
    logic              mirror_positions;
    logic              swap_rows;
    logic              blink_first;
    logic              blink_second;
    logic              flash_first;
    logic              flash_second;
    logic              flash_both;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0]      first_row;
    logic [ROW_W-1:0]      second_row;
    logic [SHIFT_BITS-1:0] shift_word;
    logic                  rewrite;
    logic [DUTY_W-1:0]     duty_percent;
  } out_t;

endpackage
`default_nettype wire

### sv/pilb_if.sv
// Valid/ready channel interfaces for the blinker's input and result transactions.
// Depends on pilb_pkg for the payload types.
`default_nettype none
interface pilb_in_if;
  logic          valid;
  logic          ready;
  pilb_pkg::in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pilb_out_if;
  logic           valid;
  logic           ready;
  pilb_pkg::out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### sv/position_indicator_led_blinker.sv
// Position indicator LED blinker: input register, row logic, result register.
// Depends on pilb_pkg and the channel interfaces in pilb_if.sv.
// Path: the input transaction loads s1_item_r, the row logic works on it, and out_item_r drives the result.
// Throughput: one transaction per cycle while out_ch.ready holds, set by the single input and result register pair.
// Reset: synchronous active-low; blink counter and last rows clear, position_count to 8.
`default_nettype none
module position_indicator_led_blinker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pilb_in_if.sink                            in_ch,
  pilb_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pilb_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [pilb_pkg::PDATA_W-1:0]  pwdata,
  output logic      [pilb_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  import pilb_pkg::*;

  logic              s1_valid_r;
  in_t               s1_item_r;
  logic              out_valid_r;
  out_t              out_item_r;
  out_t              res_nxt;
  logic [CNT_W-1:0]  blink_count_r;
  logic [CNT_W-1:0]  blink_count_nxt;
  logic [CNT_W:0]    blink_sum;
  logic [ROW_W-1:0]  last_first_row_r;
  logic [ROW_W-1:0]  last_second_row_r;
  logic [PCNT_W-1:0] position_count_r;
  logic              advance;
  logic              in_ready;
  logic              cfg_wr;
  logic              first_half;
  logic [POS_W-1:0]  cur_pos;
  logic [POS_W-1:0]  opt_pos;
  logic [POS_W+1:0]  cur_m;
  logic [POS_W+1:0]  opt_m;
  logic [ROW_W-1:0]  row1;
  logic [ROW_W-1:0]  row2;
  logic [DUTY_W-1:0] duty;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ready     = !s1_valid_r || advance;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.payload = out_item_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_POSITION_COUNT);
  assign prdata = (paddr[PADDR_W-1] == REG_POSITION_COUNT)
                  ? {{(PDATA_W-PCNT_W){1'b0}}, position_count_r} : '0;

  assign first_half      = blink_count_r < CNT_W'(BLINK_HALF);
  assign blink_sum       = {1'b0, blink_count_r} + (CNT_W+1)'(1);
  assign blink_count_nxt = (blink_sum >= (CNT_W+1)'(BLINK_PERIOD)) ? '0 : blink_sum[CNT_W-1:0];

  always_comb begin
    cur_pos = s1_item_r.swap_rows ? s1_item_r.optimal_position : s1_item_r.current_position;
    opt_pos = s1_item_r.swap_rows ? s1_item_r.current_position : s1_item_r.optimal_position;
    if (s1_item_r.mirror_positions) begin
      cur_m = {1'b0, position_count_r} - (POS_W+2)'(1) - {2'b00, cur_pos};
      opt_m = {1'b0, position_count_r} - (POS_W+2)'(1) - {2'b00, opt_pos};
    end else begin
      cur_m = {2'b00, cur_pos};
      opt_m = {2'b00, opt_pos};
    end
    row1 = (cur_m[POS_W+1:POS_W] == 2'b00) ? (ROW_W'(1) << cur_m[POS_W-1:0]) : '0;
    row2 = (opt_m[POS_W+1:POS_W] == 2'b00) ? (ROW_W'(1) << opt_m[POS_W-1:0]) : '0;
    duty = (s1_item_r.brightness_setting > MAX_DUTY) ? '0
           : MAX_DUTY - s1_item_r.brightness_setting;

    if (s1_item_r.blink_first && first_half) row1 = '0;
    if (s1_item_r.blink_second && first_half) row2 = '0;
    if (s1_item_r.flash_first) begin
      if (first_half) begin
        row1 = '0;
      end else begin
        row1 = FULL_ROW;
        duty = FLASH_DUTY;
      end
    end
    if (s1_item_r.flash_second) begin
      if (first_half) begin
        row2 = '0;
      end else begin
        row2 = FULL_ROW;
        duty = FLASH_DUTY;
      end
    end
    if (s1_item_r.flash_both) begin
      row1 = first_half ? '0 : FULL_ROW;
      row2 = first_half ? FULL_ROW : '0;
      duty = FLASH_DUTY;
    end

    res_nxt.first_row    = row1;
    res_nxt.second_row   = row2;
    res_nxt.duty_percent = duty;
    res_nxt.rewrite      = (row1 != last_first_row_r) || (row2 != last_second_row_r);
    for (int k = 0; k < ROW_W; k++) begin
      res_nxt.shift_word[2*k]   = row1[k];
      res_nxt.shift_word[2*k+1] = row2[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      blink_count_r     <= '0;
      last_first_row_r  <= '0;
      last_second_row_r <= '0;
      position_count_r  <= PCNT_RESET;
    end else begin
      if (cfg_wr) position_count_r <= pwdata[PCNT_W-1:0];
      if (in_ready) s1_valid_r <= in_ch.valid;
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          blink_count_r <= blink_count_nxt;
          if (res_nxt.rewrite) begin
            last_first_row_r  <= row1;
            last_second_row_r <= row2;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) s1_item_r <= in_ch.payload;
    if (advance && s1_valid_r) out_item_r <= res_nxt;
  end

endmodule
`default_nettype wire

### bench/position_indicator_led_blinker_test.sv
// Self-checking bench for position_indicator_led_blinker: a directed table, then random
// display ticks over several position counts and handshake idling patterns.
// Depends on pilb_pkg and the channel interfaces in pilb_if.sv.
module position_indicator_led_blinker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pilb_pkg::*;

  localparam int DIR_ROWS     = 19;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [PADDR_W-1:0] POS_COUNT_ADDR = PADDR_W'(4 * REG_POSITION_COUNT);
  localparam logic [PADDR_W-1:0] UNUSED_ADDR    = 3'd4;

  localparam logic [6:0] F_NONE   = 7'b0000000;
  localparam logic [6:0] F_MIRROR = 7'b1000000;
  localparam logic [6:0] F_SWAP   = 7'b0100000;
  localparam logic [6:0] F_BLINK1 = 7'b0010000;
  localparam logic [6:0] F_BLINK2 = 7'b0001000;
  localparam logic [6:0] F_FLASH1 = 7'b0000100;
  localparam logic [6:0] F_FLASH2 = 7'b0000010;
  localparam logic [6:0] F_FLASHB = 7'b0000001;
  localparam logic [6:0] F_ALL    = 7'b1111111;

  localparam out_t NO_WANT = '0;

  typedef struct packed {
    in_t  stim;
    logic typed;
    out_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  pilb_in_if  in_ch();
  pilb_out_if out_ch();

  position_indicator_led_blinker DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #2 clk = ~clk;

  logic [PCNT_W-1:0] pos_count   = PCNT_RESET;
  logic [3:0]        blink_cnt   = '0;
  logic [ROW_W-1:0]  last_first  = '0;
  logic [ROW_W-1:0]  last_second = '0;

  out_t     pending_frames[$];
  dir_row_t dir_tab[DIR_ROWS];
  int       mismatches   = 0;
  int       quiet_cycles = 0;
  int       idle_pct     = 0;
  int       stall_pct    = 0;
  int       hold_len     = 0;

  function automatic in_t frame_in(input int cur, input int opt, input int bright,
                                   input logic [6:0] flags);
    return {POS_W'(cur), POS_W'(opt), DUTY_W'(bright), flags};
  endfunction

  function automatic out_t led_frame(input in_t f);
    int cur_i, opt_i, tmp, k;
    logic [ROW_W-1:0]      row_a, row_b;
    logic [DUTY_W-1:0]     duty;
    logic [SHIFT_BITS-1:0] word;
    logic                  early;
    out_t                  res;
    cur_i = int'(f.current_position);
    opt_i = int'(f.optimal_position);
    if (f.swap_rows) begin
      tmp   = cur_i;
      cur_i = opt_i;
      opt_i = tmp;
    end
    if (f.mirror_positions) begin
      cur_i = int'(pos_count) - 1 - cur_i;
      opt_i = int'(pos_count) - 1 - opt_i;
    end
    row_a = (cur_i >= 0 && cur_i <= 7) ? ROW_W'(1) << cur_i : '0;
    row_b = (opt_i >= 0 && opt_i <= 7) ? ROW_W'(1) << opt_i : '0;
    duty  = (f.brightness_setting > MAX_DUTY) ? '0 : MAX_DUTY - f.brightness_setting;
    early = (blink_cnt < BLINK_HALF);
    if (f.blink_first && early) row_a = '0;
    if (f.blink_second && early) row_b = '0;
    if (f.flash_first) begin
      if (early) begin
        row_a = '0;
      end else begin
        row_a = FULL_ROW;
        duty  = FLASH_DUTY;
      end
    end
    if (f.flash_second) begin
      if (early) begin
        row_b = '0;
      end else begin
        row_b = FULL_ROW;
        duty  = FLASH_DUTY;
      end
    end
    if (f.flash_both) begin
      row_a = early ? '0 : FULL_ROW;
      row_b = early ? FULL_ROW : '0;
      duty  = FLASH_DUTY;
    end
    for (k = 0; k < ROW_W; k++) begin
      word[2*k]   = row_a[k];
      word[2*k+1] = row_b[k];
    end
    res.first_row    = row_a;
    res.second_row   = row_b;
    res.shift_word   = word;
    res.rewrite      = (row_a != last_first) || (row_b != last_second);
    res.duty_percent = duty;
    if (res.rewrite) begin
      last_first  = row_a;
      last_second = row_b;
    end
    blink_cnt = blink_cnt + 1'b1;
    if (blink_cnt >= BLINK_PERIOD) blink_cnt = '0;
    return res;
  endfunction

  function automatic in_t rand_frame();
    in_t f;
    f.current_position   = POS_W'($urandom_range(0, 7));
    f.optimal_position   = POS_W'($urandom_range(0, 7));
    f.brightness_setting = DUTY_W'(($urandom_range(0, 9) == 0) ? $urandom_range(101, 127)
                                                               : $urandom_range(0, 100));
    f.mirror_positions   = 1'($urandom_range(0, 1));
    f.swap_rows          = 1'($urandom_range(0, 1));
    f.blink_first        = ($urandom_range(0, 99) < 30);
    f.blink_second       = ($urandom_range(0, 99) < 30);
    f.flash_first        = ($urandom_range(0, 99) < 15);
    f.flash_second       = ($urandom_range(0, 99) < 15);
    f.flash_both         = ($urandom_range(0, 99) < 15);
    return f;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == POS_COUNT_ADDR) pos_count = data[PCNT_W-1:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic reg_read_check();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = POS_COUNT_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    check_field("position_count", {{(32-PCNT_W){1'b0}}, pos_count}, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic offer_frame(input in_t f, input logic typed, input out_t want);
    out_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.payload = f;
    in_ch.valid   = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predicted = led_frame(f);
    pending_frames.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [PCNT_W-1:0] count, input int send_idle,
                           input int recv_stall, input int hold, input int frames);
    logic [PDATA_W-1:0] word;
    in_ch.valid = 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    word = $urandom;
    reg_write(UNUSED_ADDR, word);
    word[PCNT_W-1:0] = count;
    reg_write(POS_COUNT_ADDR, word);
    reg_read_check();
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    hold_len  = hold;
    repeat (frames) offer_frame(rand_frame(), 1'b0, NO_WANT);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ch.ready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: result with no frame pending: %h", $time, out_ch.payload);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        check_field("first_row", 32'(want.first_row), 32'(out_ch.payload.first_row));
        check_field("second_row", 32'(want.second_row), 32'(out_ch.payload.second_row));
        check_field("shift_word", 32'(want.shift_word), 32'(out_ch.payload.shift_word));
        check_field("rewrite", 32'(want.rewrite), 32'(out_ch.payload.rewrite));
        check_field("duty_percent", 32'(want.duty_percent),
                    32'(out_ch.payload.duty_percent));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;

    dir_tab[0]  = {frame_in(0, 7, 0, F_NONE), 1'b1,
                   out_t'({8'h01, 8'h80, 16'h8001, 1'b1, 7'd100})};
    dir_tab[1]  = {frame_in(0, 7, 100, F_NONE), 1'b1,
                   out_t'({8'h01, 8'h80, 16'h8001, 1'b0, 7'd0})};
    dir_tab[2]  = {frame_in(7, 0, 127, F_NONE), 1'b1,
                   out_t'({8'h80, 8'h01, 16'h4002, 1'b1, 7'd0})};
    dir_tab[3]  = {frame_in(3, 4, 10, F_FLASHB), 1'b1,
                   out_t'({8'h00, 8'hff, 16'haaaa, 1'b1, 7'd30})};
    dir_tab[4]  = {frame_in(1, 2, 50, F_BLINK1 | F_BLINK2), 1'b0, NO_WANT};
    dir_tab[5]  = {frame_in(1, 2, 50, F_BLINK1 | F_BLINK2), 1'b0, NO_WANT};
    dir_tab[6]  = {frame_in(4, 6, 75, F_FLASH1), 1'b0, NO_WANT};
    dir_tab[7]  = {frame_in(4, 6, 75, F_FLASH2), 1'b0, NO_WANT};
    dir_tab[8]  = {frame_in(4, 6, 75, F_FLASHB), 1'b0, NO_WANT};
    dir_tab[9]  = {frame_in(4, 6, 75, F_FLASH1 | F_FLASH2 | F_FLASHB), 1'b0, NO_WANT};
    dir_tab[10] = {frame_in(4, 6, 75, F_FLASH1 | F_FLASH2), 1'b0, NO_WANT};
    dir_tab[11] = {frame_in(2, 5, 20, F_SWAP), 1'b0, NO_WANT};
    dir_tab[12] = {frame_in(0, 7, 20, F_MIRROR), 1'b0, NO_WANT};
    dir_tab[13] = {frame_in(1, 6, 20, F_MIRROR | F_SWAP), 1'b0, NO_WANT};
    dir_tab[14] = {frame_in(7, 7, 1, F_ALL), 1'b0, NO_WANT};
    dir_tab[15] = {frame_in(3, 3, 101, F_NONE), 1'b0, NO_WANT};
    dir_tab[16] = {frame_in(5, 5, 99, F_BLINK1), 1'b0, NO_WANT};
    dir_tab[17] = {frame_in(5, 5, 99, F_BLINK1), 1'b0, NO_WANT};
    dir_tab[18] = {frame_in(6, 1, 64, F_MIRROR | F_BLINK2), 1'b0, NO_WANT};

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    reg_read_check();
    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_frame(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
    end

    run_phase(4'd1, 0, 0, 0, 80);
    run_phase(4'd15, 81, 0, 0, 80);
    run_phase(4'd0, 0, 81, 0, 80);
    run_phase(4'd5, 21, 21, 0, 80);
    run_phase(4'd8, 0, 0, HOLD_CYCLES, 80);
    run_phase(PCNT_W'($urandom_range(0, 15)), 21, 21, 0, 80);

    in_ch.valid = 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
